### rtl/core/svt_pkg.sv
// ----------------------------------------------------------------------------
// svt_pkg
// Shared types, codes and helpers for the valve PWM timer block.
// ----------------------------------------------------------------------------
package svt_pkg;

    localparam int SVT_CHANNELS    = 8;
    localparam int SVT_TIMER_SLOTS = 16;

    // Object index of the fault flag
    localparam logic [3:0] FAULT_OBJ = 4'd8;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_READ    = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_STEP_BASE   = 3'd0,
        REG_STEP_RELOAD = 3'd1,
        REG_SUBSTITUTE  = 3'd2,
        REG_WATCH_EN    = 3'd3,
        REG_WATCH_BASE  = 3'd4,
        REG_WATCH_RLD   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] object_index;
        logic [7:0] write_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] output_pattern;
        logic       pattern_changed;
        logic       fault_report;
        logic [7:0] read_value;
    } out_item_t;

    typedef struct packed {
        logic [31:0] step_base_table;
        logic [63:0] step_reload_table;
        logic [63:0] substitute_table;
        logic [7:0]  watch_enable;
        logic [3:0]  watch_base;
        logic [7:0]  watch_reload;
    } cfg_regs_t;

    // Per-beat command broadcast to every channel
    typedef struct packed {
        logic       tick;
        logic       cnt_en;
        logic       write;
        logic       restart;
        logic [3:0] sel;
        logic [3:0] obj;
        logic [7:0] wdata;
    } chan_cmd_t;

    // Index of the lowest set bit; zero for an all-zero word
    function automatic logic [3:0] low_bit_idx(input logic [15:0] v);
        logic [3:0] idx;
        idx = '0;
        for (int i = 15; i >= 0; i--) begin
            if (v[i]) idx = 4'(i);
        end
        return idx;
    endfunction

endpackage

### rtl/core/svt_cfg.sv
// ----------------------------------------------------------------------------
// svt_cfg
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module svt_cfg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_data,
    output svt_pkg::cfg_regs_t   cfg_out
);
    import svt_pkg::*;

    cfg_regs_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_STEP_BASE:   cfg_reg.step_base_table   <= cfg_data[31:0];
                REG_STEP_RELOAD: cfg_reg.step_reload_table <= cfg_data;
                REG_SUBSTITUTE:  cfg_reg.substitute_table  <= cfg_data;
                REG_WATCH_EN:    cfg_reg.watch_enable      <= cfg_data[7:0];
                REG_WATCH_BASE:  cfg_reg.watch_base        <= cfg_data[3:0];
                REG_WATCH_RLD:   cfg_reg.watch_reload      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/svt_chan.sv
// ----------------------------------------------------------------------------
// svt_chan
// One valve channel: step timer, step position, value, start-up phase,
// supervision timer and output bit.
// ----------------------------------------------------------------------------
module svt_chan #(
    parameter int CHAN_IDX    = 0,
    parameter int CHANNELS    = svt_pkg::SVT_CHANNELS,
    parameter int TIMER_SLOTS = svt_pkg::SVT_TIMER_SLOTS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  svt_pkg::chan_cmd_t   cmd,
    input  svt_pkg::cfg_regs_t   cfg,
    output logic                 pat_next,
    output logic                 fired,
    output logic [7:0]           value
);
    import svt_pkg::*;

    // Timers whose slot lies beyond the available slots never count
    localparam bit STEP_LIVE  = (CHAN_IDX < TIMER_SLOTS);
    localparam bit WATCH_LIVE = ((CHANNELS + CHAN_IDX) < TIMER_SLOTS);

    logic [3:0] step_pre_reg,  step_pre_next;
    logic [7:0] step_rem_reg,  step_rem_next;
    logic [3:0] watch_pre_reg, watch_pre_next;
    logic [7:0] watch_rem_reg, watch_rem_next;
    logic [7:0] pos_reg,       pos_next;
    logic [7:0] value_reg,     value_next;
    logic       startup_reg,   startup_next;
    logic       pat_reg;

    logic [3:0] my_base;
    logic [7:0] my_reload;
    logic [7:0] my_subst;
    logic       watch_on;
    logic       hit;
    logic [7:0] step_rem_t;
    logic [7:0] watch_rem_t;
    logic [7:0] pos_inc;
    logic       step_fire;
    logic       watch_fire;

    assign my_base   = cfg.step_base_table[4*CHAN_IDX +: 4];
    assign my_reload = cfg.step_reload_table[8*CHAN_IDX +: 8];
    assign my_subst  = cfg.substitute_table[8*CHAN_IDX +: 8];
    assign watch_on  = cfg.watch_enable[CHAN_IDX];
    assign hit       = (cmd.obj == 4'(CHAN_IDX));

    always_comb begin
        step_rem_t = step_rem_reg;
        if (STEP_LIVE && cmd.cnt_en && step_pre_reg == cmd.sel && step_rem_reg != 8'd0) begin
            step_rem_t = step_rem_reg - 8'd1;
        end
        watch_rem_t = watch_rem_reg;
        if (WATCH_LIVE && cmd.cnt_en && watch_pre_reg == cmd.sel
                && watch_rem_reg != 8'd0) begin
            watch_rem_t = watch_rem_reg - 8'd1;
        end
    end

    assign pos_inc    = pos_reg + 8'd1;
    assign step_fire  = (step_rem_t == 8'd0);
    assign watch_fire = cmd.tick && watch_on && (watch_rem_t == 8'd0);

    always_comb begin
        step_pre_next  = step_pre_reg;
        step_rem_next  = step_rem_reg;
        watch_pre_next = watch_pre_reg;
        watch_rem_next = watch_rem_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        startup_next   = startup_reg;
        pat_next       = pat_reg;

        if (cmd.tick) begin
            step_rem_next  = step_rem_t;
            watch_rem_next = watch_rem_t;
            if (step_fire) begin
                step_pre_next = my_base;
                step_rem_next = my_reload;
                pos_next      = pos_inc;
                // step compare uses the value from before any substitution
                if (!startup_reg) begin
                    if (pos_inc > value_reg) pat_next = 1'b0;
                    if (pos_inc < value_reg) pat_next = 1'b1;
                end else if (pos_inc != 8'd0) begin
                    pat_next = 1'b1;
                end else begin
                    startup_next = 1'b0;
                end
            end
            if (watch_fire) begin
                value_next     = my_subst;
                watch_rem_next = cfg.watch_reload;
            end
        end else if (cmd.write && hit) begin
            if (cmd.wdata != 8'd0 && value_reg == 8'd0) begin
                startup_next = 1'b1;
                pos_next     = 8'd0;
            end
            value_next = cmd.wdata;
            if (watch_on) watch_rem_next = cfg.watch_reload;
        end else if (cmd.restart) begin
            value_next    = 8'd0;
            step_pre_next = my_base;
            step_rem_next = my_reload;
            if (watch_on) begin
                watch_pre_next = cfg.watch_base;
                watch_rem_next = cfg.watch_reload;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_pre_reg  <= '0;
            step_rem_reg  <= '0;
            watch_pre_reg <= '0;
            watch_rem_reg <= '0;
            pos_reg       <= '0;
            value_reg     <= '0;
            startup_reg   <= 1'b0;
            pat_reg       <= 1'b0;
        end else begin
            step_pre_reg  <= step_pre_next;
            step_rem_reg  <= step_rem_next;
            watch_pre_reg <= watch_pre_next;
            watch_rem_reg <= watch_rem_next;
            pos_reg       <= pos_next;
            value_reg     <= value_next;
            startup_reg   <= startup_next;
            pat_reg       <= pat_next;
        end
    end

    assign fired = watch_fire;
    assign value = value_reg;

endmodule

### rtl/core/step_pwm_valve_timers_top.sv
// ----------------------------------------------------------------------------
// step_pwm_valve_timers_top
// A result is registered in m_data and is valid in the cycle after its input beat.
// Throughput: one beat per cycle unless the result side stalls; all channel timers
// update in parallel in the accepting cycle, and a single output register decouples the sides.
// Reset (aresetn low, synchronous) clears all timers, positions, values,
// patterns and configuration registers to zero.
// ----------------------------------------------------------------------------
module step_pwm_valve_timers_top #(
    parameter int CHANNELS    = svt_pkg::SVT_CHANNELS,
    parameter int TIMER_SLOTS = svt_pkg::SVT_TIMER_SLOTS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  svt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output svt_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import svt_pkg::*;

    cfg_regs_t  cfg;
    chan_cmd_t  cmd;
    logic       beat;

    logic [15:0] tick_reg, tick_next;
    logic        fault_reg, fault_next;
    logic [7:0]  reported_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;
    out_item_t   result;

    logic [CHANNELS-1:0] pat_bits;
    logic [CHANNELS-1:0] fired_bits;
    logic [7:0]          values [CHANNELS];
    logic [7:0]          pattern;
    logic [7:0]          rd;

    svt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_out   (cfg)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign beat    = s_valid && s_ready;

    always_comb begin
        tick_next   = tick_reg + 16'd1;
        cmd.tick    = beat && (s_data.operation == OP_TICK);
        cmd.write   = beat && (s_data.operation == OP_WRITE);
        cmd.restart = beat && (s_data.operation == OP_RESTART);
        // wrap to zero decrements nothing
        cmd.cnt_en  = cmd.tick && (tick_next != 16'd0);
        cmd.sel     = low_bit_idx(tick_next);
        cmd.obj     = s_data.object_index;
        cmd.wdata   = s_data.write_byte;
    end

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        svt_chan #(
            .CHAN_IDX    (c),
            .CHANNELS    (CHANNELS),
            .TIMER_SLOTS (TIMER_SLOTS)
        ) u_chan (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .cfg      (cfg),
            .pat_next (pat_bits[c]),
            .fired    (fired_bits[c]),
            .value    (values[c])
        );
    end

    always_comb begin
        pattern = '0;
        rd      = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            pattern[c] = pat_bits[c];
            if (s_data.object_index == 4'(c)) rd = values[c];
        end
        if (s_data.object_index == FAULT_OBJ) rd = {7'd0, fault_reg};
        if (s_data.operation != OP_READ) rd = '0;
    end

    always_comb begin
        fault_next = fault_reg;
        if (cmd.tick && (|fired_bits)) begin
            fault_next = 1'b1;
        end else if (cmd.write && s_data.object_index == FAULT_OBJ) begin
            fault_next = s_data.write_byte[0];
        end else if (cmd.restart) begin
            fault_next = 1'b0;
        end
    end

    always_comb begin
        result.output_pattern  = pattern;
        result.pattern_changed = (pattern != reported_reg);
        result.fault_report    = cmd.tick && (|fired_bits);
        result.read_value      = rd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg     <= '0;
            fault_reg    <= 1'b0;
            reported_reg <= '0;
        end else if (beat) begin
            if (cmd.tick) begin
                tick_reg <= tick_next;
            end else if (cmd.restart) begin
                tick_reg <= '0;
            end
            fault_reg    <= fault_next;
            reported_reg <= pattern;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (beat) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat) m_data_reg <= result;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### tb/sv/step_pwm_valve_timers_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// step_pwm_valve_timers_checker
// Watches the input, result and register channels of the valve PWM block,
// keeps its own copy of the timers, positions and channel values, works out
// the result of every accepted input beat and compares it field by field with
// the result beats in order. Hands the failure count and the number of
// results still due to the testbench top.
// ----------------------------------------------------------------------------
module step_pwm_valve_timers_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  svt_pkg::in_item_t   s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  svt_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output int                  fail_count,
    output int                  pending_count
);
    import svt_pkg::*;

    localparam int NCH    = SVT_CHANNELS;
    localparam int NSLOTS = SVT_TIMER_SLOTS;

    // register copies
    logic [31:0] step_base_r;
    logic [63:0] step_reload_r;
    logic [63:0] subst_r;
    logic [7:0]  watch_en_r;
    logic [3:0]  watch_base_r;
    logic [7:0]  watch_reload_r;

    // block state
    logic [15:0] ticks;
    logic [3:0]  step_pre  [NCH];
    logic [7:0]  step_rem  [NCH];
    logic [3:0]  watch_pre [NCH];
    logic [7:0]  watch_rem [NCH];
    logic [7:0]  position  [NCH];
    logic [7:0]  level     [NCH];
    logic [7:0]  in_startup;
    logic        fault_flag;
    logic [7:0]  pattern;
    logic [7:0]  pattern_seen;

    out_item_t   due_results[$];

    task automatic clear_state();
        step_base_r    = '0;
        step_reload_r  = '0;
        subst_r        = '0;
        watch_en_r     = '0;
        watch_base_r   = '0;
        watch_reload_r = '0;
        ticks          = '0;
        for (int c = 0; c < NCH; c++) begin
            step_pre[c]  = '0;
            step_rem[c]  = '0;
            watch_pre[c] = '0;
            watch_rem[c] = '0;
            position[c]  = '0;
            level[c]     = '0;
        end
        in_startup   = '0;
        fault_flag   = 1'b0;
        pattern      = '0;
        pattern_seen = '0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        case (idx)
            REG_STEP_BASE:   step_base_r    = data[31:0];
            REG_STEP_RELOAD: step_reload_r  = data;
            REG_SUBSTITUTE:  subst_r        = data;
            REG_WATCH_EN:    watch_en_r     = data[7:0];
            REG_WATCH_BASE:  watch_base_r   = data[3:0];
            REG_WATCH_RLD:   watch_reload_r = data[7:0];
            default: ;
        endcase
    endtask

    task automatic advance_valves(input in_item_t beat_in, output out_item_t res);
        logic [7:0] rd;
        logic       fired;
        int         sel;
        logic [2:0] ch;
        rd    = '0;
        fired = 1'b0;
        sel   = 0;
        ch    = beat_in.object_index[2:0];
        case (beat_in.operation)
            OP_TICK: begin
                ticks = ticks + 16'd1;
                // no counter moves on the tick that wraps the count
                if (ticks != '0) begin
                    while (sel < 15 && !ticks[sel]) sel++;
                    for (int c = 0; c < NCH; c++) begin
                        if (c < NSLOTS && step_pre[c] == 4'(sel) && step_rem[c] != '0)
                            step_rem[c] = step_rem[c] - 8'd1;
                        if (NCH + c < NSLOTS && watch_pre[c] == 4'(sel) && watch_rem[c] != '0)
                            watch_rem[c] = watch_rem[c] - 8'd1;
                    end
                end
                for (int c = 0; c < NCH; c++) begin
                    if (step_rem[c] == '0) begin
                        step_pre[c] = step_base_r[4*c +: 4];
                        step_rem[c] = step_reload_r[8*c +: 8];
                        position[c] = position[c] + 8'd1;
                        if (!in_startup[c]) begin
                            if (position[c] > level[c]) pattern[c] = 1'b0;
                            if (position[c] < level[c]) pattern[c] = 1'b1;
                        end else if (position[c] != '0) begin
                            pattern[c] = 1'b1;
                        end else begin
                            in_startup[c] = 1'b0;
                        end
                    end
                end
                for (int c = 0; c < NCH; c++) begin
                    if (watch_rem[c] == '0 && watch_en_r[c]) begin
                        level[c]     = subst_r[8*c +: 8];
                        watch_rem[c] = watch_reload_r;
                        fired        = 1'b1;
                    end
                end
                if (fired) fault_flag = 1'b1;
            end
            OP_WRITE: begin
                if (beat_in.object_index < NCH) begin
                    if (beat_in.write_byte != '0 && level[ch] == '0) begin
                        in_startup[ch] = 1'b1;
                        position[ch]   = '0;
                    end
                    level[ch] = beat_in.write_byte;
                    if (watch_en_r[ch])
                        watch_rem[ch] = watch_reload_r;
                end else if (beat_in.object_index == FAULT_OBJ) begin
                    fault_flag = beat_in.write_byte[0];
                end
            end
            OP_READ: begin
                if (beat_in.object_index < NCH)
                    rd = level[ch];
                else if (beat_in.object_index == FAULT_OBJ)
                    rd = {7'd0, fault_flag};
            end
            default: begin
                // restart keeps start-up flags, positions and patterns
                ticks = '0;
                for (int c = 0; c < NCH; c++) begin
                    level[c] = '0;
                    if (watch_en_r[c]) begin
                        watch_pre[c] = watch_base_r;
                        watch_rem[c] = watch_reload_r;
                    end
                    step_pre[c] = step_base_r[4*c +: 4];
                    step_rem[c] = step_reload_r[8*c +: 8];
                end
                fault_flag = 1'b0;
            end
        endcase
        res.output_pattern  = pattern;
        res.pattern_changed = (pattern != pattern_seen);
        res.fault_report    = fired;
        res.read_value      = rd;
        pattern_seen        = pattern;
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : watch_channels
        out_item_t want;
        out_item_t res;
        if (!aresetn) begin
            clear_state();
            due_results.delete();
        end else begin
            // results leave no earlier than the cycle after their input beat
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("result beat with nothing due: %p", m_data);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("output_pattern", want.output_pattern, m_data.output_pattern);
                    check_field("pattern_changed", {7'd0, want.pattern_changed},
                                {7'd0, m_data.pattern_changed});
                    check_field("fault_report", {7'd0, want.fault_report},
                                {7'd0, m_data.fault_report});
                    check_field("read_value", want.read_value, m_data.read_value);
                end
            end
            // an input beat in the same cycle still sees the old registers
            if (s_valid && s_ready) begin
                advance_valves(s_data, res);
                due_results.push_back(res);
            end
            if (cfg_valid && cfg_ready)
                write_reg(cfg_index, cfg_data);
        end
        pending_count = due_results.size();
    end

endmodule

### tb/sv/step_pwm_valve_timers_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// step_pwm_valve_timers_top_tb
// Drives the valve PWM block with a short directed sequence and random beats
// under several register settings, with random gaps on the input side and
// random stalls on the result side. The checker beside the block predicts
// and compares.
// ----------------------------------------------------------------------------
module step_pwm_valve_timers_top_tb;
    import svt_pkg::*;

    localparam int         CYCLE_LIMIT  = 1000000;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam logic [3:0] NO_OBJ_LO    = 4'd9;
    localparam logic [3:0] NO_OBJ_HI    = 4'd15;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    in_item_t    s_data    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    int fail_count;
    int pending_count;
    int gap_pct   = 0;
    int stall_pct = 0;
    int cycles    = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    step_pwm_valve_timers_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    step_pwm_valve_timers_checker pwm_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic in_item_t beat(input op_t op, input logic [3:0] idx,
                                      input logic [7:0] val);
        in_item_t it;
        it.operation    = op;
        it.object_index = idx;
        it.write_byte   = val;
        return it;
    endfunction

    function automatic in_item_t rand_beat();
        int pick;
        int obj_pick;
        int val_pick;
        in_item_t it;
        pick     = $urandom_range(99);
        obj_pick = $urandom_range(9);
        val_pick = $urandom_range(3);
        if (pick < 55)      it.operation = OP_TICK;
        else if (pick < 80) it.operation = OP_WRITE;
        else if (pick < 96) it.operation = OP_READ;
        else                it.operation = OP_RESTART;
        if (obj_pick < 8)       it.object_index = 4'($urandom_range(7));
        else if (obj_pick == 8) it.object_index = FAULT_OBJ;
        else                    it.object_index = 4'($urandom_range(15));
        // zero and full scale often, to hit start-up and the PWM ends
        if (val_pick == 0)      it.write_byte = 8'h00;
        else if (val_pick == 1) it.write_byte = 8'hFF;
        else                    it.write_byte = 8'($urandom_range(255));
        return it;
    endfunction

    // all tasks start and end at a falling edge
    task automatic send_beat(input in_item_t it);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_beat(rand_beat());
    endtask

    task automatic wait_results_done();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    // leaves cfg_valid high; load_regs lowers it after the last write
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic load_regs(input logic [31:0] bases, input logic [63:0] reloads,
                             input logic [63:0] substs, input logic [7:0] wen,
                             input logic [3:0] wbase, input logic [7:0] wrld);
        reg_write(REG_STEP_BASE, {32'd0, bases});
        reg_write(REG_STEP_RELOAD, reloads);
        reg_write(REG_SUBSTITUTE, substs);
        reg_write(REG_WATCH_EN, {56'd0, wen});
        reg_write(REG_WATCH_BASE, {60'd0, wbase});
        reg_write(REG_WATCH_RLD, {56'd0, wrld});
        cfg_valid <= 1'b0;
    endtask

    // fast timers so the PWM and the watchdog move within a few hundred beats
    task automatic load_fast_regs();
        logic [31:0] bases;
        logic [63:0] reloads;
        for (int c = 0; c < SVT_CHANNELS; c++) begin
            bases[4*c +: 4]   = 4'($urandom_range(2));
            reloads[8*c +: 8] = 8'($urandom_range(3));
        end
        load_regs(bases, reloads, {$urandom, $urandom}, 8'($urandom_range(255)),
                  4'($urandom_range(2)), 8'($urandom_range(12)));
    endtask

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        gap_pct   = 29;
        stall_pct = 67;

        // directed: watchdog on the upper four channels, zero reload on channel 0
        reg_write(REG_SPARE_LO, '1);
        reg_write(REG_SPARE_HI, '1);
        load_regs(32'h0000_0000, 64'h0706_0504_0302_0100, 64'hFF7F_8001_5AA5_0300,
                  8'hF0, 4'h0, 8'h02);
        send_beat(beat(OP_RESTART, 4'd0, 8'h00));
        send_beat(beat(OP_WRITE, 4'd0, 8'hFF));
        send_beat(beat(OP_WRITE, 4'd1, 8'h01));
        send_beat(beat(OP_WRITE, 4'd7, 8'h80));
        send_beat(beat(OP_WRITE, FAULT_OBJ, 8'hFF));
        send_beat(beat(OP_READ, FAULT_OBJ, 8'h00));
        send_beat(beat(OP_WRITE, FAULT_OBJ, 8'hFE));
        send_beat(beat(OP_READ, FAULT_OBJ, 8'hFF));
        send_beat(beat(OP_WRITE, NO_OBJ_HI, 8'hFF));
        send_beat(beat(OP_READ, NO_OBJ_HI, 8'h00));
        send_beat(beat(OP_READ, NO_OBJ_LO, 8'h55));
        repeat (6) send_beat(beat(OP_TICK, 4'd0, 8'h00));
        send_beat(beat(OP_READ, 4'd4, 8'h00));
        send_beat(beat(OP_READ, 4'd0, 8'h00));
        send_beat(beat(OP_WRITE, 4'd0, 8'h00));
        send_beat(beat(OP_WRITE, 4'd0, 8'h00));
        send_beat(beat(OP_TICK, NO_OBJ_HI, 8'hFF));
        send_beat(beat(OP_READ, FAULT_OBJ, 8'h00));
        send_beat(beat(OP_RESTART, NO_OBJ_HI, 8'hFF));
        send_beat(beat(OP_TICK, 4'd0, 8'h00));
        wait_results_done();

        load_fast_regs();
        send_random(280);
        wait_results_done();

        gap_pct   = 67;
        stall_pct = 29;
        load_regs('1, '1, '1, 8'hFF, 4'hF, 8'hFF);
        send_random(100);
        wait_results_done();
        load_fast_regs();
        send_random(180);
        wait_results_done();

        gap_pct   = 0;
        stall_pct = 0;
        load_regs('0, '0, '0, 8'h00, 4'h0, 8'h00);
        send_random(140);
        wait_results_done();

        load_fast_regs();
        send_random(150);
        wait_results_done();

        repeat (4) @(negedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/svt_pkg.sv
rtl/core/svt_cfg.sv
rtl/core/svt_chan.sv
rtl/core/step_pwm_valve_timers_top.sv
tb/sv/step_pwm_valve_timers_checker.sv
tb/sv/step_pwm_valve_timers_top_tb.sv
